// ===== rtl/core/fpa_pkg.sv =====
// Shared types, opcodes and constants for the 16.16 fixed-point ALU.
// No dependencies; fpa_front, fpa_div_step and the ALU core import this package.
`default_nettype none
package fpa_pkg;

  typedef enum logic [2:0] {
    OP_MUL         = 3'd0,
    OP_DIV         = 3'd1,
    OP_RATIO       = 3'd2,
    OP_ROUND       = 3'd3,
    OP_FIX_TO_INT  = 3'd4,
    OP_INT_TO_FIX  = 3'd5,
    OP_FIX_TO_FRAC = 3'd6,
    OP_FRAC_TO_FIX = 3'd7
  } op_t;

  localparam int unsigned FIX_SHIFT  = 16;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam logic [31:0] HALF_ONE   = 32'h0000_8000;
  localparam logic [31:0] SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG    = 32'h8000_0000;

  // one quotient bit per stage over the 48-bit shifted dividend
  localparam int unsigned DIV_STEPS  = 32 + FIX_SHIFT;
  localparam int unsigned LAST       = DIV_STEPS + 1;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [31:0] res;    // simple or multiply result
    logic        msgn;   // product sign
    logic [31:0] am;
    logic [31:0] bm;
    logic [63:0] prod;
    logic        nneg;
    logic        qsgn;   // quotient sign
    logic        dz;
    logic [31:0] dmag;
    logic [31:0] rem;
    logic [31:0] dvd;    // dividend bits not yet shifted in
    logic [31:0] quo;
  } stage_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpa_if.sv =====
// Valid/ready channel interfaces for the ALU request and response beats.
// Depends on nothing.
`default_nettype none
interface fpa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result;
  logic        divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fpa_front.sv =====
// Input decode: simple shift results, multiply and divide magnitudes.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output fpa_pkg::stage_t  st
);
  import fpa_pkg::*;

  logic [31:0] num, den, rnd;

  always_comb begin
    num = (op_t'(opcode) == OP_RATIO) ? {{16{a[15]}}, a[15:0]} : a;
    den = (op_t'(opcode) == OP_RATIO) ? {{16{b[15]}}, b[15:0]} : b;
    rnd = a + HALF_ONE;
    st = '0;
    st.op = op_t'(opcode);
    case (op_t'(opcode))
      OP_ROUND:       st.res = $signed(rnd) >>> FIX_SHIFT;
      OP_FIX_TO_INT:  st.res = $signed(a) >>> FIX_SHIFT;
      OP_INT_TO_FIX:  st.res = a << FIX_SHIFT;
      OP_FIX_TO_FRAC: st.res = a << FRAC_SHIFT;
      OP_FRAC_TO_FIX: st.res = $signed(a) >>> FRAC_SHIFT;
      default:        st.res = '0;
    endcase
    st.msgn = a[31] ^ b[31];
    st.am   = a[31] ? (32'd0 - a) : a;
    st.bm   = b[31] ? (32'd0 - b) : b;
    st.nneg = num[31];
    st.qsgn = num[31] ^ den[31];
    st.dz   = (den == 32'd0);
    st.dmag = den[31] ? (32'd0 - den) : den;
    st.dvd  = num[31] ? (32'd0 - num) : num;
    st.rem  = '0;
    st.quo  = '0;
  end
endmodule
`default_nettype wire

// ===== rtl/core/fpa_div_step.sv =====
// One restoring-division step: shifts in a dividend bit, yields one quotient bit.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_step (
  input  wire fpa_pkg::stage_t d,
  output fpa_pkg::stage_t      q
);
  import fpa_pkg::*;

  logic [32:0] trial;
  logic        take;

  always_comb begin
    trial = {d.rem, d.dvd[31]};
    take  = (trial >= {1'b0, d.dmag});
    q     = d;
    q.rem = take ? 32'(trial - {1'b0, d.dmag}) : trial[31:0];
    q.dvd = {d.dvd[30:0], 1'b0};
    q.quo = {d.quo[30:0], take};
  end
endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_16_16_alu_core.sv =====
// 16.16 fixed-point ALU: mul, div, ratio and shift conversions.
// Depends on fpa_pkg, fpa_if, fpa_front and fpa_div_step.
//
// Usage: requests arrive on req (opcode, operand_a, operand_b) and each one
// yields exactly one beat on rsp (result, divide_by_zero), in order.
// Every operation takes the same path of LAST+1 = 50 register stages: an
// input stage, 48 one-bit division stages (the 48-bit shifted dividend sets
// the depth) and a final select stage that is also the output register.
// Throughput is one beat per cycle while rsp is ready. The multiplier sits
// in stage 1 and its sign fix-up in stage 2, alongside the division steps.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up: while rsp is stalled, req stays ready until all stages are full.
// Reset clears every valid bit; nothing is in flight afterwards.
`default_nettype none
module fixed_point_16_16_alu_core (
  input wire logic  clk,
  input wire logic  rst,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);
  import fpa_pkg::*;

  stage_t s [0:LAST];
  stage_t nx [0:LAST];
  stage_t s_next [0:LAST];
  logic   ld [0:LAST+1];
  stage_t front;
  logic [31:0] qs;

  fpa_front u_front (
    .opcode(req.opcode), .a(req.operand_a), .b(req.operand_b), .st(front)
  );

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    fpa_div_step u_step (.d(s[k-1]), .q(nx[k]));
  end

  always_comb begin
    ld[LAST+1] = rsp.ready;
    for (int k = LAST; k >= 0; k--) ld[k] = !s[k].valid || ld[k+1];
  end

  always_comb begin
    nx[0] = front;
    nx[0].valid = req.valid;
    qs = s[LAST-1].qsgn ? (32'd0 - s[LAST-1].quo) : s[LAST-1].quo;
    nx[LAST] = s[LAST-1];
    if (s[LAST-1].op == OP_DIV || s[LAST-1].op == OP_RATIO) begin
      if (s[LAST-1].dz) nx[LAST].res = s[LAST-1].nneg ? SAT_NEG : SAT_POS;
      else              nx[LAST].res = qs;
    end else begin
      nx[LAST].dz = 1'b0;
    end
  end

  // product in stage 1, its sign fix-up in stage 2
  always_comb begin
    for (int k = 0; k <= LAST; k++) s_next[k] = nx[k];
    s_next[1].prod = {32'd0, s[0].am} * {32'd0, s[0].bm};
    if (s[1].op == OP_MUL)
      s_next[2].res = s[1].msgn ? 32'((64'd0 - s[1].prod) >> FIX_SHIFT)
                                : 32'(s[1].prod >> FIX_SHIFT);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      if (rst) begin
        s[k].valid <= 1'b0;
      end else if (ld[k]) begin
        s[k] <= s_next[k];
      end
    end
  end

  assign req.ready          = ld[0];
  assign rsp.valid          = s[LAST].valid;
  assign rsp.result         = s[LAST].res;
  assign rsp.divide_by_zero = s[LAST].dz;

  a_flag_op: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> s[LAST].op == OP_DIV || s[LAST].op == OP_RATIO)
    else $error("divide-by-zero flag on a non-divide beat");

  a_flag_sat: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> rsp.result == SAT_POS || rsp.result == SAT_NEG)
    else $error("divide-by-zero beat not saturated");

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    s[0].valid && !ld[1] |=> s[0].valid && $stable(s[0].dvd))
    else $error("stalled input stage lost its beat");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s[0].valid && s[LAST].valid && !rsp.ready)
    else $error("input refused with room in the pipeline");
endmodule
`default_nettype wire
